/* src/mavlink_v1_frame_encoder_top_defines.svh */
// Assertion helpers shared by the encoder modules.
// Both sample on clk_i and stay quiet while rst_ni is low.
`ifndef MAVLINK_V1_FRAME_ENCODER_TOP_DEFINES_SVH
`define MAVLINK_V1_FRAME_ENCODER_TOP_DEFINES_SVH

// Property must hold at every clock edge.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition must never be seen at a clock edge.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/mlv1e_pkg.sv */
package mlv1e_pkg;

  localparam logic [7:0]  STX_V1   = 8'hFE;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  typedef enum logic [0:0] {
    REG_SYSTEM_ID    = 1'b0,
    REG_COMPONENT_ID = 1'b1
  } reg_index_e;

  // One classified item on its way to the byte sequencer.
  typedef struct packed {
    logic       is_start;
    logic       has_data;
    logic       close;
    logic [7:0] len;
    logic [7:0] msg;
    logic [7:0] seq;
    logic [7:0] data;
    logic [7:0] extra;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_HEAD,
    ST_STX,
    ST_LEN,
    ST_SEQ,
    ST_SYS,
    ST_COMP,
    ST_MSG,
    ST_DATA,
    ST_CRCL,
    ST_CRCH
  } step_e;

  // CRC-16/MCRF4XX, one byte.
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

/* src/mavlink_v1_frame_encoder_top.sv */
// MAVLink v1 frame encoder. A start item (frame_start_i high) opens a frame and yields
// the six header bytes, the first payload byte when the length is nonzero, and the
// two CRC bytes when the frame closes with it; each later item yields one payload
// byte, plus the CRC pair on the last one. Items with no frame open are dropped.
// Input items are taken one per cycle while the queue has room, into a queue of
// QueueDepth classified items; frame bytes leave through one output register at one
// byte per cycle while out_ready_i is high, so a start item yields 7 to 9 bytes and a
// payload item 1 or 3, and that byte count sets the sustained input rate. Write
// system_id (index 0) and component_id (index 1) only while the block is idle.
module mavlink_v1_frame_encoder_top import mlv1e_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       frame_start_i,
  input  logic [7:0] message_id_i,
  input  logic [7:0] payload_length_i,
  input  logic [7:0] crc_extra_byte_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       end_of_frame_o,
  output logic       end_of_run_o
);

  logic push, pop, q_full, q_empty;
  cmd_t push_cmd, head_cmd;

  mlv1e_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .frame_start_i    (frame_start_i),
    .message_id_i     (message_id_i),
    .payload_length_i (payload_length_i),
    .crc_extra_byte_i (crc_extra_byte_i),
    .data_byte_i      (data_byte_i),
    .q_full_i         (q_full),
    .push_o           (push),
    .cmd_o            (push_cmd)
  );

  mlv1e_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (pop),
    .head_o  (head_cmd)
  );

  mlv1e_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_empty_i      (q_empty),
    .head_i         (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_byte_o   (frame_byte_o),
    .end_of_frame_o (end_of_frame_o),
    .end_of_run_o   (end_of_run_o)
  );

endmodule

/* src/mlv1e_front.sv */
module mlv1e_front import mlv1e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       frame_start_i,
  input  logic [7:0] message_id_i,
  input  logic [7:0] payload_length_i,
  input  logic [7:0] crc_extra_byte_i,
  input  logic [7:0] data_byte_i,
  input  logic       q_full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  logic [7:0] seq_q, seq_d;
  logic [7:0] rem_q, rem_d;
  logic [7:0] extra_q, extra_d;
  logic       open_q, open_d;
  logic       accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    seq_d   = seq_q;
    rem_d   = rem_q;
    extra_d = extra_q;
    open_d  = open_q;
    push_o  = 1'b0;

    cmd_o.is_start = frame_start_i;
    cmd_o.has_data = frame_start_i ? (payload_length_i != 8'd0) : 1'b1;
    cmd_o.close    = frame_start_i ? (payload_length_i <= 8'd1) : (rem_q == 8'd1);
    cmd_o.len      = payload_length_i;
    cmd_o.msg      = message_id_i;
    cmd_o.seq      = seq_q;
    cmd_o.data     = data_byte_i;
    cmd_o.extra    = frame_start_i ? crc_extra_byte_i : extra_q;

    if (accept) begin
      if (frame_start_i) begin
        push_o  = 1'b1;
        seq_d   = seq_q + 8'd1;
        extra_d = crc_extra_byte_i;
        rem_d   = (payload_length_i != 8'd0) ? payload_length_i - 8'd1 : 8'd0;
        open_d  = payload_length_i > 8'd1;
      end else if (open_q) begin
        push_o = 1'b1;
        rem_d  = rem_q - 8'd1;
        open_d = rem_q != 8'd1;
      end
      // drop a byte with no frame open
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= 8'd0;
      rem_q   <= 8'd0;
      extra_q <= 8'd0;
      open_q  <= 1'b0;
    end else begin
      seq_q   <= seq_d;
      rem_q   <= rem_d;
      extra_q <= extra_d;
      open_q  <= open_d;
    end
  end

endmodule

/* src/mlv1e_queue.sv */
`include "mavlink_v1_frame_encoder_top_defines.svh"

module mlv1e_queue import mlv1e_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic empty_o,
  input  logic pop_i,
  output cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign head_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `ASSERT_NEVER(q_no_overflow_a, push_i && full_o && !pop_i, "queue push while full")
  `ASSERT_CLK(q_count_bound_a, count_q <= CntW'(Depth), "queue count beyond depth")

endmodule

/* src/mlv1e_back.sv */
`include "mavlink_v1_frame_encoder_top_defines.svh"

module mlv1e_back import mlv1e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  input  logic       q_empty_i,
  input  cmd_t       head_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       end_of_frame_o,
  output logic       end_of_run_o
);

  step_e       step_q, step_d, cur, nxt;
  logic [15:0] crc_q, crc_d, crc_upd;
  logic [7:0]  sys_q, comp_q;
  logic [7:0]  crc_in, byte_out;
  logic        done, load;
  logic        out_valid_q;
  logic [7:0]  byte_q;
  logic        eof_q, eor_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_q  <= 8'd1;
      comp_q <= 8'd1;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_SYSTEM_ID) begin
        sys_q <= cfg_data_i;
      end else begin
        comp_q <= cfg_data_i;
      end
    end
  end

  // Advance one frame byte whenever an item waits and the output register is free or being taken.
  assign load  = !q_empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = load && done;

  always_comb begin
    cur = step_q;
    if (step_q == ST_HEAD) begin
      cur = head_i.is_start ? ST_STX : ST_DATA;
    end
    nxt    = ST_HEAD;
    done   = 1'b0;
    crc_in = head_i.data;
    case (cur)
      ST_STX: begin
        crc_in = STX_V1;
        nxt    = ST_LEN;
      end
      ST_LEN: begin
        crc_in = head_i.len;
        nxt    = ST_SEQ;
      end
      ST_SEQ: begin
        crc_in = head_i.seq;
        nxt    = ST_SYS;
      end
      ST_SYS: begin
        crc_in = sys_q;
        nxt    = ST_COMP;
      end
      ST_COMP: begin
        crc_in = comp_q;
        nxt    = ST_MSG;
      end
      ST_MSG: begin
        crc_in = head_i.msg;
        nxt    = head_i.has_data ? ST_DATA : ST_CRCL;
      end
      ST_DATA: begin
        crc_in = head_i.data;
        nxt    = head_i.close ? ST_CRCL : ST_HEAD;
        done   = !head_i.close;
      end
      ST_CRCL: begin
        crc_in = head_i.extra;
        nxt    = ST_CRCH;
      end
      ST_CRCH: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b1;
      end
    endcase
  end

  assign crc_upd = crc_step(crc_q, crc_in);

  always_comb begin
    byte_out = crc_in;
    crc_d    = crc_q;
    step_d   = step_q;
    if (cur == ST_CRCL) begin
      byte_out = crc_upd[7:0];
    end else if (cur == ST_CRCH) begin
      byte_out = crc_q[15:8];
    end
    if (load) begin
      step_d = done ? ST_HEAD : nxt;
      if (cur == ST_STX || cur == ST_CRCH) begin
        crc_d = CRC_INIT;
      end else begin
        crc_d = crc_upd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_HEAD;
      crc_q       <= CRC_INIT;
      out_valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      crc_q  <= crc_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= byte_out;
      eof_q  <= cur == ST_CRCH;
      eor_q  <= done;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign frame_byte_o   = byte_q;
  assign end_of_frame_o = eof_q;
  assign end_of_run_o   = eor_q;

  `ASSERT_CLK(eof_ends_run_a, out_valid_q && eof_q |-> eor_q, "end of frame not last of item")
  `ASSERT_NEVER(pop_when_empty_a, pop_o && q_empty_i, "pop from empty queue")

endmodule
